@@ sv/block_peak_rms_meter_macros.svh @@
// assertion macros for the block peak and rms meter
`ifndef BLOCK_PEAK_RMS_METER_MACROS_SVH
`define BLOCK_PEAK_RMS_METER_MACROS_SVH

`ifndef SYNTHESIS

`define BPRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BPRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BPRM_ASSERT_SAME(label, ante, cons, msg)

`define BPRM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/bprm_pkg.sv @@
`default_nettype none

package bprm_pkg;

    localparam int unsigned SAMPLE_W   = 24;
    localparam int unsigned LEVEL_W    = 24;
    localparam int unsigned PROD_W     = 48;
    localparam int unsigned SUM_W      = 61;
    localparam int unsigned RAD_W      = 62;
    localparam int unsigned ROOT_W     = 31;
    localparam int unsigned RREM_W     = 33;
    localparam int unsigned DIV_STEPS  = 61;
    localparam int unsigned ROOT_STEPS = 31;
    localparam int unsigned STEP_W     = 6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_PREP,
        S_DIV,
        S_ROOT_PREP,
        S_ROOT,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic take;
        logic square;
        logic accum;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic out_load;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/bprm_ctrl.sv @@
`default_nettype none

`include "block_peak_rms_meter_macros.svh"

module bprm_ctrl
    import bprm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_valid,
    input  wire logic i_s_last,
    output logic      o_s_ready,
    output logic      o_m_valid,
    input  wire logic i_m_ready,
    output t_cmd      o_cmd
);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_last, n_last;
    logic                r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_last    = r_last;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_last     = i_s_last;
                    n_state    = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = r_last ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                o_cmd.div_start = 1'b1;
                n_step          = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_ROOT_PREP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROOT_PREP: begin
                o_cmd.root_start = 1'b1;
                n_step           = '0;
                n_state          = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_LOAD;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

    `BPRM_ASSERT_SAME(a_load_no_overwrite, o_cmd.out_load, !r_out_valid || i_m_ready, "result overwritten while pending")
    `BPRM_ASSERT_NEXT(a_div_to_root, (r_state == S_DIV) && (r_step == STEP_W'(DIV_STEPS - 1)), r_state == S_ROOT_PREP, "divider did not hand over to square root")
    `BPRM_ASSERT_SAME(a_prep_only_on_last, r_state == S_PREP, r_last, "block end without last item")

endmodule

`default_nettype wire

@@ sv/bprm_dp.sv @@
`default_nettype none

`include "block_peak_rms_meter_macros.svh"

module bprm_dp
    import bprm_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_SAMPLES = 32768,
    parameter int unsigned SAMPLE_BITS       = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    output logic [2*LEVEL_W-1:0]       o_data,
    output logic                       o_overflow
);

    localparam int unsigned CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int unsigned PAD   = SAMPLE_W - SAMPLE_BITS;

    // accumulation
    logic [LEVEL_W-1:0]  r_mag;
    logic [PROD_W-1:0]   r_sq;
    logic [LEVEL_W-1:0]  r_peak;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic                r_sat;

    // divider and square root
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_den;
    logic                r_zero;
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W-1:0]   r_root;
    logic [RREM_W-1:0]   r_rrem;
    logic [LEVEL_W-1:0]  r_res_peak;
    logic                r_res_sat;

    logic signed [SAMPLE_W-1:0] w_left;
    logic signed [SAMPLE_W-1:0] w_sext;
    logic [SAMPLE_W:0]          w_wide;
    logic [SAMPLE_W:0]          w_abs;
    logic [SUM_W:0]             w_sum_next;
    logic [CNT_W:0]             w_div_sh;
    logic [CNT_W:0]             w_div_diff;
    logic                       w_div_ge;
    logic [RREM_W+1:0]          w_rt_sh;
    logic [RREM_W+1:0]          w_rt_trial;
    logic [RREM_W+1:0]          w_rt_diff;
    logic                       w_rt_ge;

    // sign extend from the configured sample width, then take the magnitude
    assign w_left = signed'(i_sample << PAD);
    assign w_sext = w_left >>> PAD;
    assign w_wide = {w_sext[SAMPLE_W-1], w_sext};
    assign w_abs  = w_sext[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - w_wide) : w_wide;

    assign w_sum_next = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    assign w_div_sh   = {r_rem, r_quo[SUM_W-1]};
    assign w_div_ge   = w_div_sh >= {1'b0, r_den};
    assign w_div_diff = w_div_sh - {1'b0, r_den};

    assign w_rt_sh    = {r_rrem, r_rad[RAD_W-1 -: 2]};
    assign w_rt_trial = (RREM_W+2)'({r_root, 2'b01});
    assign w_rt_ge    = w_rt_sh >= w_rt_trial;
    assign w_rt_diff  = w_rt_sh - w_rt_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_cmd.square) begin
                if (r_mag > r_peak) begin
                    r_peak <= r_mag;
                end
            end
            if (i_cmd.accum) begin
                if (r_count < CNT_W'(MAX_BLOCK_SAMPLES)) begin
                    if (w_sum_next[SUM_W]) begin
                        r_sum <= '1;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= w_sum_next[SUM_W-1:0];
                    end
                    r_count <= r_count + 1'b1;
                end else begin
                    r_sat <= 1'b1;
                end
            end
            if (i_cmd.div_start) begin
                r_peak  <= '0;
                r_sum   <= '0;
                r_count <= '0;
                r_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mag <= w_abs[LEVEL_W-1:0];
        end
        if (i_cmd.square) begin
            r_sq <= PROD_W'(r_mag) * PROD_W'(r_mag);
        end
        if (i_cmd.div_start) begin
            r_quo      <= r_sum;
            r_rem      <= '0;
            r_den      <= r_count;
            r_zero     <= (r_count == '0);
            r_res_peak <= r_peak;
            r_res_sat  <= r_sat;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], w_div_ge};
            r_rem <= w_div_ge ? w_div_diff[CNT_W-1:0] : w_div_sh[CNT_W-1:0];
        end
        if (i_cmd.root_start) begin
            r_rad  <= r_zero ? '0 : RAD_W'(r_quo);
            r_root <= '0;
            r_rrem <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], w_rt_ge};
            r_rrem <= w_rt_ge ? w_rt_diff[RREM_W-1:0] : w_rt_sh[RREM_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_data     <= {r_root[LEVEL_W-1:0], r_res_peak};
            o_overflow <= r_res_sat;
        end
    end

    `BPRM_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_BLOCK_SAMPLES), "sample count past bound")
    `BPRM_ASSERT_NEXT(a_sat_at_bound, i_cmd.accum && (r_count == CNT_W'(MAX_BLOCK_SAMPLES)), r_sat, "count at bound without overflow flag")

endmodule

`default_nettype wire

@@ sv/block_peak_rms_meter.sv @@
// Block peak and rms level meter. Signed samples of all channels of a block
// arrive pooled on the slave stream, tlast on the final sample of the block.
// For each block one result leaves on the master stream: tdata holds the peak
// absolute value (bits 23:0) and floor(sqrt(floor(sum of squares / count)))
// (bits 47:24), both unsigned Q1.23; tuser is set when the count bound or the
// 61-bit sum saturated. One item is processed at a time: an item without tlast
// is captured, squared on the multiplier and accumulated; an item with tlast
// also passes the bit-serial divider and the two-bits-per-cycle square root,
// and its result may wait for a still pending result in the output register.
`default_nettype none

module block_peak_rms_meter
    import bprm_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_SAMPLES = 32768,
    parameter int unsigned SAMPLE_BITS       = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,   // sample
    input  wire logic                 s_axis_tlast,   // last_in_block
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [2*LEVEL_W-1:0]      m_axis_tdata,   // peak_level, rms_level
    output logic                      m_axis_tuser    // overflow
);

    t_cmd w_cmd;

    bprm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_last  (s_axis_tlast),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd)
    );

    bprm_dp #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .SAMPLE_BITS       (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_sample   (s_axis_tdata),
        .o_data     (m_axis_tdata),
        .o_overflow (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import bprm_pkg::*;

    localparam int unsigned BLOCK_CAP  = 32768;
    localparam logic [63:0] SUM_LIMIT  = (64'd1 << SUM_W) - 64'd1;
    localparam int unsigned RAND_ITEMS = 2000;

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_EDGE,
        FILL_HALF
    } t_fill;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                eob;
    } t_sample_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [LEVEL_W-1:0] rms;
        logic               ovf;
    } t_level_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [SAMPLE_W-1:0]  s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*LEVEL_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    t_sample_item  pend_q[$];
    t_level_result level_q[$];

    logic [LEVEL_W-1:0] meter_peak = '0;
    logic [SUM_W-1:0]   meter_sum = '0;
    int unsigned        meter_count = 0;
    logic               meter_sat = 1'b0;

    logic quiet = 1'b0;
    logic hold_off = 1'b0;
    logic src_idle_en = 1'b1;
    logic snk_idle_en = 1'b1;
    int   src_gap = 0;
    int   snk_stall = 0;
    int   samples_in = 0;
    int   results_seen = 0;
    int   ovf_seen = 0;
    int   fail_count = 0;

    block_peak_rms_meter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r[LEVEL_W-1:0];
    endfunction

    function automatic void absorb_sample(input t_sample_item it);
        logic [LEVEL_W-1:0] mag;
        logic [63:0]        sq;
        logic [63:0]        acc;
        t_level_result      res;
        mag = it.smp[SAMPLE_W-1] ? (~it.smp + 1'b1) : it.smp;
        if (mag > meter_peak) meter_peak = mag;
        if (meter_count < BLOCK_CAP) begin
            sq  = 64'(mag) * 64'(mag);
            acc = 64'(meter_sum) + sq;
            if (acc > SUM_LIMIT) begin
                meter_sum = SUM_LIMIT[SUM_W-1:0];
                meter_sat = 1'b1;
            end else begin
                meter_sum = acc[SUM_W-1:0];
            end
            meter_count++;
        end else begin
            meter_sat = 1'b1;
        end
        if (it.eob) begin
            res.peak = meter_peak;
            res.rms  = (meter_count != 0) ? root_floor(64'(meter_sum) / 64'(meter_count)) : '0;
            res.ovf  = meter_sat;
            level_q.push_back(res);
            meter_peak  = '0;
            meter_sum   = '0;
            meter_count = 0;
            meter_sat   = 1'b0;
        end
    endfunction

    function automatic void check_level(input logic [2*LEVEL_W-1:0] data, input logic usr);
        t_level_result want;
        t_level_result got;
        got.peak = data[LEVEL_W-1:0];
        got.rms  = data[2*LEVEL_W-1:LEVEL_W];
        got.ovf  = usr;
        results_seen++;
        if (usr) ovf_seen++;
        if (level_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result with no block pending: peak %0d rms %0d ovf %0b",
                         got.peak, got.rms, got.ovf);
        end else begin
            want = level_q.pop_front();
            if (got.peak !== want.peak || got.rms !== want.rms || got.ovf !== want.ovf) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d exp peak %0d rms %0d ovf %0b got peak %0d rms %0d ovf %0b",
                             results_seen, want.peak, want.rms, want.ovf,
                             got.peak, got.rms, got.ovf);
            end
        end
    endfunction

    function automatic void queue_sample(input logic [SAMPLE_W-1:0] s, input logic l);
        t_sample_item it;
        it.smp = s;
        it.eob = l;
        pend_q.push_back(it);
    endfunction

    function automatic logic [SAMPLE_W-1:0] signed_within(input int unsigned span);
        logic [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom_range(0, span));
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample(input t_fill style);
        logic [SAMPLE_W-1:0] v;
        case (style)
            FILL_SMALL: v = signed_within(1023);
            FILL_HALF:  v = signed_within((1 << 22) - 1);
            FILL_EDGE: begin
                case ($urandom_range(0, 6))
                    0:       v = 24'h7FFFFF;
                    1:       v = 24'h800000;
                    2:       v = 24'h000000;
                    3:       v = 24'hFFFFFF;
                    4:       v = 24'h000001;
                    5:       v = 24'h800001;
                    default: v = SAMPLE_W'($urandom());
                endcase
            end
            default:    v = SAMPLE_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic void queue_block(input int len, input t_fill style);
        for (int i = 0; i < len; i++)
            queue_sample(rand_sample(style), i == len - 1);
    endfunction

    // sender: items from pend_q, predicted as they are accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) begin
                absorb_sample(pend_q.pop_front());
                samples_in++;
                if ($urandom_range(0, 199) == 0) src_idle_en = !src_idle_en;
            end
            if (src_gap != 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (src_idle_en && !quiet && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end else if (pend_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pend_q[0].smp;
                s_axis_tlast  <= pend_q[0].eob;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: level results checked in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_level(m_axis_tdata, m_axis_tuser);
                if ($urandom_range(0, 7) == 0) snk_idle_en = !snk_idle_en;
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (snk_stall != 0) begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end else if (snk_idle_en && !quiet && $urandom_range(0, 9) == 0) begin
                snk_stall = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (results_seen >= 30);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (500) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #24_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int    rnd_items;
        int    len;
        t_fill style;

        // single-sample blocks at the extremes, then short multi-sample blocks
        queue_sample(24'h7FFFFF, 1'b1);
        queue_sample(24'h800000, 1'b1);
        queue_sample(24'h000000, 1'b1);
        queue_sample(24'hFFFFFF, 1'b1);
        queue_sample(24'h000001, 1'b1);
        queue_sample(24'h7FFFFF, 1'b0);
        queue_sample(24'h800000, 1'b0);
        queue_sample(24'h000000, 1'b0);
        queue_sample(24'h123456, 1'b0);
        queue_sample(24'hEDCBAA, 1'b1);
        queue_sample(24'h000003, 1'b0);
        queue_sample(24'hFFFFFC, 1'b0);
        queue_sample(24'h000005, 1'b0);
        queue_sample(24'h000000, 1'b1);
        queue_sample(24'h800001, 1'b0);
        queue_sample(24'h555555, 1'b0);
        queue_sample(24'hAAAAAA, 1'b1);
        for (int i = 0; i < 4; i++) queue_sample(24'h400000, i == 3);

        rnd_items = 0;
        while (rnd_items < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    len = 1;
                8:       len = $urandom_range(41, 250);
                9:       len = $urandom_range(2, 8);
                default: len = $urandom_range(2, 40);
            endcase
            style = t_fill'($urandom_range(0, 3));
            queue_block(len, style);
            rnd_items += len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() > 300) @(posedge i_clk);
        quiet <= 1'b1;
        while (pend_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (level_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        $display("covered %0d samples in %0d blocks, %0d of them flagged overflow",
                 samples_in, results_seen, ovf_seen);
        $display("mismatches: %0d", fail_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
